/* rtl/core/sprite_quad_vertex_generator_unit_assert.svh */
// Assertion macros for the sprite quad vertex generator.
// Used by the top level; no other dependencies.
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQVG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sqvg: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SQVG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sqvg: next-cycle check failed");

`endif

/* rtl/core/sqvg_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the
// sprite quad vertex generator. No dependencies.
package sqvg_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int ATAN_IDX_W   = 5;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   localparam int MAX_QUADS = 4096;
   localparam int QUAD_W    = 13;
   localparam int SLOT_W    = 14;
   localparam int TERM_W    = 62;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIP_Y    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_QUADS = 1'b1;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] width;
      logic signed [31:0] height;
      logic [15:0]        angle;
      logic [31:0]        rgba;
      logic               frame_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0]  vert_x;
      logic signed [31:0]  vert_y;
      logic                tex_u;
      logic                tex_v;
      logic [31:0]         vert_rgba;
      logic [SLOT_W-1:0]   slot;
      logic                flush;
      logic                last;
   } rsp_payload_type;

   // Cosine and sine in Q2.30.
   typedef struct packed {
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } trig_type;

   // Sprite geometry after the optional y inversion.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] width;
      logic signed [31:0] height;
   } geom_type;

   // Partial sums per corner half. The a and c terms carry the centre and the
   // rounding constant; pos is for the positive half offset, neg for the other.
   typedef struct packed {
      logic [TERM_W-1:0] a_pos;
      logic [TERM_W-1:0] a_neg;
      logic [TERM_W-1:0] b_pos;
      logic [TERM_W-1:0] b_neg;
      logic [TERM_W-1:0] c_pos;
      logic [TERM_W-1:0] c_neg;
      logic [TERM_W-1:0] d_pos;
      logic [TERM_W-1:0] d_neg;
   } terms_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic signed [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [31:0] r;
      case (idx)
         5'd0:    r = 32'sd536870912;
         5'd1:    r = 32'sd316933405;
         5'd2:    r = 32'sd167458907;
         5'd3:    r = 32'sd85004756;
         5'd4:    r = 32'sd42667331;
         5'd5:    r = 32'sd21354465;
         5'd6:    r = 32'sd10679838;
         5'd7:    r = 32'sd5340245;
         5'd8:    r = 32'sd2670163;
         5'd9:    r = 32'sd1335086;
         5'd10:   r = 32'sd667544;
         5'd11:   r = 32'sd333772;
         5'd12:   r = 32'sd166886;
         5'd13:   r = 32'sd83443;
         5'd14:   r = 32'sd41721;
         5'd15:   r = 32'sd20860;
         5'd16:   r = 32'sd10430;
         5'd17:   r = 32'sd5215;
         5'd18:   r = 32'sd2607;
         5'd19:   r = 32'sd1303;
         5'd20:   r = 32'sd651;
         5'd21:   r = 32'sd325;
         5'd22:   r = 32'sd162;
         5'd23:   r = 32'sd81;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/sqvg_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
// Depends on sqvg_pkg for the step count, gain and arctangent table.
module sqvg_cordic
   import sqvg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] angle,
   output logic        done,
   output trig_type    trig
);

   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic [1:0]         quad_ff, quad_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [15:0]        turned;
   logic [14:0]        residue;
   logic signed [31:0] dx, dy, atan_v;

   always_comb begin
      // Rotate the circle by an eighth turn so the residue is centred on zero.
      turned  = angle + 16'd8192;
      residue = {1'b0, turned[13:0]} - 15'd8192;
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      atan_v  = atan_turn(ATAN_IDX_W'(step_ff));

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = {residue[14], residue, 16'b0};
         quad_in = turned[15:14];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[31]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      step_ff <= step_in;
   end

   always_comb begin
      case (quad_ff)
         2'd0: begin
            trig.cos_v = x_ff;
            trig.sin_v = y_ff;
         end
         2'd1: begin
            trig.cos_v = -y_ff;
            trig.sin_v = x_ff;
         end
         2'd2: begin
            trig.cos_v = -x_ff;
            trig.sin_v = -y_ff;
         end
         default: begin
            trig.cos_v = y_ff;
            trig.sin_v = -x_ff;
         end
      endcase
   end

   assign done = done_ff;

endmodule

/* rtl/core/sqvg_expand.sv */
// Shared 32x32 multiplier that forms the four half-size by trig products
// and folds them into per-corner partial sums. Depends on sqvg_pkg.
module sqvg_expand
   import sqvg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  trig_type  trig,
   input  geom_type  geom,
   output logic      done,
   output terms_type terms
);

   // Product order through the multiplier.
   localparam logic [1:0] PROD_XC = 2'd0;   // half width times cos
   localparam logic [1:0] PROD_XS = 2'd1;   // half width times sin
   localparam logic [1:0] PROD_YS = 2'd2;   // half height times sin
   localparam logic [1:0] PROD_YC = 2'd3;   // half height times cos

   logic [1:0]         issue_ff, issue_in;
   logic               issue_busy_ff, issue_busy_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [1:0]         prod_sel_ff, prod_sel_in;
   logic               prod_valid_ff, prod_valid_in;
   terms_type          terms_ff, terms_in;
   logic               done_ff, done_in;

   logic signed [31:0] half_w, half_h, op_a, op_b, post_trig;
   logic [TERM_W-1:0]  off_x, off_y, off_v, p_v, corr_v, pos_v, neg_v;
   logic               odd_bit;

   // Floor halves of the positive corner offsets. The negative offsets are
   // -half - lsb, which the post stage applies to the product.
   assign half_w = geom.width  >>> 1;
   assign half_h = geom.height >>> 1;
   assign off_x  = {geom.center_x, 1'b1, 29'b0};
   assign off_y  = {geom.center_y, 1'b1, 29'b0};

   always_comb begin
      op_a = issue_ff[1] ? half_h : half_w;
      op_b = (issue_ff == PROD_XS || issue_ff == PROD_YS) ? trig.sin_v : trig.cos_v;
      prod_in = op_a * op_b;

      issue_in      = issue_ff;
      issue_busy_in = issue_busy_ff;
      prod_valid_in = 1'b0;
      prod_sel_in   = issue_ff;
      if (start) begin
         issue_in      = PROD_XC;
         issue_busy_in = 1'b1;
      end else if (issue_busy_ff) begin
         prod_valid_in = 1'b1;
         issue_in      = issue_ff + 1'b1;
         if (issue_ff == PROD_YC) begin
            issue_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      post_trig = (prod_sel_ff == PROD_XS || prod_sel_ff == PROD_YS) ?
                  trig.sin_v : trig.cos_v;
      odd_bit   = prod_sel_ff[1] ? geom.height[0] : geom.width[0];
      unique case (prod_sel_ff)
         PROD_XC: off_v = off_x;
         PROD_XS: off_v = off_y;
         PROD_YS: off_v = '0;
         PROD_YC: off_v = '0;
      endcase
      p_v    = prod_ff[TERM_W-1:0];
      corr_v = odd_bit ? {{(TERM_W-32){post_trig[31]}}, post_trig} : '0;
      pos_v  = off_v + p_v;
      neg_v  = off_v - p_v - corr_v;

      terms_in = terms_ff;
      done_in  = 1'b0;
      if (prod_valid_ff) begin
         unique case (prod_sel_ff)
            PROD_XC: begin
               terms_in.a_pos = pos_v;
               terms_in.a_neg = neg_v;
            end
            PROD_XS: begin
               terms_in.c_pos = pos_v;
               terms_in.c_neg = neg_v;
            end
            PROD_YS: begin
               terms_in.b_pos = pos_v;
               terms_in.b_neg = neg_v;
            end
            PROD_YC: begin
               terms_in.d_pos = pos_v;
               terms_in.d_neg = neg_v;
               done_in        = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_busy_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         issue_busy_ff <= issue_busy_in;
         prod_valid_ff <= prod_valid_in;
         done_ff       <= done_in;
      end
      issue_ff    <= issue_in;
      prod_ff     <= prod_in;
      prod_sel_ff <= prod_sel_in;
      terms_ff    <= terms_in;
   end

   assign done  = done_ff;
   assign terms = terms_ff;

endmodule

/* rtl/core/sprite_quad_vertex_generator_unit.sv */
// Each sprite runs through the 16-step CORDIC and the four passes through the shared
// multiplier, then emits its four vertices; a vertex waits while the output is stalled.
// A new sprite is accepted only in idle, once the fourth vertex of the last is loaded.
// Reset (synchronous, active high): idle, output empty, quad counter 0,
// flip_y 0, max_quads 4096.
`include "sprite_quad_vertex_generator_unit_assert.svh"

module sprite_quad_vertex_generator_unit
   import sqvg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ROTATE = 4'b0010,
      ST_EXPAND = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   state_type            state_ff, state_in;
   logic                 flip_y_ff, flip_y_in;
   logic [QUAD_W-1:0]    max_quads_ff, max_quads_in;
   logic [QUAD_W-1:0]    quad_count_ff, quad_count_in;
   geom_type             geom_ff, geom_in;
   logic [31:0]          rgba_ff, rgba_in;
   logic [SLOT_W-3:0]    slot_hi_ff, slot_hi_in;
   logic                 flushed_ff, flushed_in;
   logic [1:0]           corner_ff, corner_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic                 accept, emit_load;
   logic                 cordic_done, expand_done;
   trig_type             trig;
   terms_type            terms;
   logic [QUAD_W-1:0]    limit, qc_base, qc_use;
   logic                 full;
   logic [TERM_W-1:0]    a_sel, b_sel, c_sel, d_sel, sum_x, sum_y;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   sqvg_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .angle (req_payload.angle),
      .done  (cordic_done),
      .trig  (trig)
   );

   sqvg_expand u_expand (
      .clock (clock),
      .reset (reset),
      .start (cordic_done),
      .trig  (trig),
      .geom  (geom_ff),
      .done  (expand_done),
      .terms (terms)
   );

   // Configuration registers.
   always_comb begin
      flip_y_in    = flip_y_ff;
      max_quads_in = max_quads_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FLIP_Y:    flip_y_in    = csr_wdata[0];
            CSR_MAX_QUADS: max_quads_in = csr_wdata[QUAD_W-1:0];
         endcase
      end
   end

   // Batch accounting and sprite capture.
   always_comb begin
      if (max_quads_ff == '0) begin
         limit = QUAD_W'(1);
      end else if (max_quads_ff > QUAD_W'(MAX_QUADS)) begin
         limit = QUAD_W'(MAX_QUADS);
      end else begin
         limit = max_quads_ff;
      end
      qc_base = req_payload.frame_start ? '0 : quad_count_ff;
      full    = (qc_base >= limit);
      qc_use  = full ? '0 : qc_base;

      quad_count_in = quad_count_ff;
      geom_in       = geom_ff;
      rgba_in       = rgba_ff;
      slot_hi_in    = slot_hi_ff;
      flushed_in    = flushed_ff;
      if (accept) begin
         quad_count_in     = qc_use + 1'b1;
         geom_in.center_x  = req_payload.center_x;
         geom_in.center_y  = flip_y_ff ? -req_payload.center_y : req_payload.center_y;
         geom_in.width     = req_payload.width;
         geom_in.height    = req_payload.height;
         rgba_in           = req_payload.rgba;
         slot_hi_in        = qc_use[SLOT_W-3:0];
         flushed_in        = full;
      end
   end

   // Vertex assembly: the a/c terms already hold the centre and rounding bias.
   always_comb begin
      a_sel = corner_ff[0] ? terms.a_pos : terms.a_neg;
      c_sel = corner_ff[0] ? terms.c_pos : terms.c_neg;
      b_sel = corner_ff[1] ? terms.b_pos : terms.b_neg;
      d_sel = corner_ff[1] ? terms.d_pos : terms.d_neg;
      sum_x = a_sel - b_sel;
      sum_y = c_sel + d_sel;

      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      corner_in        = corner_ff;
      if (emit_load) begin
         rsp_in.vert_x    = sum_x[TERM_W-1:30];
         rsp_in.vert_y    = sum_y[TERM_W-1:30];
         rsp_in.tex_u     = corner_ff[0];
         rsp_in.tex_v     = !corner_ff[1];
         rsp_in.vert_rgba = rgba_ff;
         rsp_in.slot      = {slot_hi_ff, corner_ff};
         rsp_in.flush     = flushed_ff && (corner_ff == 2'd0);
         rsp_in.last      = (corner_ff == CORNER_LAST);
         rsp_valid_in     = 1'b1;
         corner_in        = corner_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_ROTATE;
         ST_ROTATE: if (cordic_done) state_in = ST_EXPAND;
         ST_EXPAND: if (expand_done) state_in = ST_EMIT;
         ST_EMIT:   if (emit_load && corner_ff == CORNER_LAST) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flip_y_ff     <= 1'b0;
         max_quads_ff  <= QUAD_W'(MAX_QUADS);
         quad_count_ff <= '0;
         corner_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flip_y_ff     <= flip_y_in;
         max_quads_ff  <= max_quads_in;
         quad_count_ff <= quad_count_in;
         corner_ff     <= corner_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      geom_ff    <= geom_in;
      rgba_ff    <= rgba_in;
      slot_hi_ff <= slot_hi_in;
      flushed_ff <= flushed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SQVG_ASSERT_NXT(a_accept_starts, clock, reset, accept, state_ff == ST_ROTATE)
   `SQVG_ASSERT_IMP(a_cordic_in_rotate, clock, reset, cordic_done, state_ff == ST_ROTATE)
   `SQVG_ASSERT_IMP(a_expand_in_expand, clock, reset, expand_done, state_ff == ST_EXPAND)
   `SQVG_ASSERT_IMP(a_last_is_corner3, clock, reset, rsp_valid && rsp_payload.last, rsp_payload.slot[1:0] == CORNER_LAST)
   `SQVG_ASSERT_IMP(a_flush_on_first, clock, reset, rsp_valid && rsp_payload.flush, rsp_payload.slot[1:0] == 2'd0)

endmodule
